@@ rtl/bof_pkg.sv @@
// Package: shared constants and types of the box overlap entity filter.
package bof_pkg;

    localparam int MAX_ENTRIES = 65536;
    localparam int FRAC_BITS   = 16;

    localparam int ID_W   = 63;
    localparam int CRD_W  = 32;
    localparam int THR_W  = 31;
    localparam int CFG_W  = 64;
    localparam int CNT_W  = 17;
    localparam int CTR_W  = ($clog2(MAX_ENTRIES + 1) > CNT_W) ? $clog2(MAX_ENTRIES + 1) : CNT_W;
    localparam int IDX_W  = 3;
    localparam int QDEPTH = 4;

    localparam logic [CTR_W-1:0] MAX_CNT = CTR_W'(MAX_ENTRIES);

    localparam logic [CFG_W-1:0] BOX_RESET = 64'h7FFF_FFFF_8000_0000;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

    // register indexes
    localparam logic [IDX_W-1:0] REG_BOX_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_BOX_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_BOX_Z     = 3'd2;
    localparam logic [IDX_W-1:0] REG_QUERY_POS = 3'd3;
    localparam logic [IDX_W-1:0] REG_SOURCE_ID = 3'd4;
    localparam logic [IDX_W-1:0] REG_PUSH_THR  = 3'd5;

    // input kinds
    localparam logic [1:0] KIND_ZERO    = 2'd0;
    localparam logic [1:0] KIND_POS     = 2'd1;
    localparam logic [1:0] KIND_NEG     = 2'd2;
    localparam logic [1:0] KIND_BAD_POS = 2'd3;

    // result kinds
    localparam logic [1:0] RES_SELECTED = 2'd0;
    localparam logic [1:0] RES_PUSHED   = 2'd1;
    localparam logic [1:0] RES_SUMMARY  = 2'd2;

    // one queue entry: all words that one input item causes
    typedef struct packed {
        logic             sel;
        logic             push;
        logic             sum;
        logic [ID_W-1:0]  id;
        logic [CTR_W-1:0] sel_cnt;
        logic [CTR_W-1:0] push_cnt;
        logic             abort;
    } entry_t;

endpackage

@@ rtl/bof_front.sv @@
// Front part: configuration registers, overlap classification and batch counters.
module bof_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bof_pkg::IDX_W-1:0]    cfg_idx,
    input  logic [bof_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bof_pkg::ID_W-1:0]     entity_id,
    input  logic signed [bof_pkg::CRD_W-1:0] min_x,
    input  logic signed [bof_pkg::CRD_W-1:0] max_x,
    input  logic signed [bof_pkg::CRD_W-1:0] min_y,
    input  logic signed [bof_pkg::CRD_W-1:0] max_y,
    input  logic signed [bof_pkg::CRD_W-1:0] min_z,
    input  logic signed [bof_pkg::CRD_W-1:0] max_z,
    input  logic signed [bof_pkg::CRD_W-1:0] pos_x,
    input  logic signed [bof_pkg::CRD_W-1:0] pos_z,
    input  logic [1:0]                   kind,
    input  logic                         last_item,
    output logic                         q_wr,
    output bof_pkg::entry_t              q_wdata,
    input  logic                         q_full
);

    localparam int CW = bof_pkg::CRD_W;

    logic [bof_pkg::CFG_W-1:0] box_x_reg, box_y_reg, box_z_reg, query_pos_reg;
    logic [bof_pkg::ID_W-1:0]  source_id_reg;
    logic [bof_pkg::THR_W-1:0] push_thr_reg;

    // stage 1: captured word
    logic                     s1_valid_reg;
    logic [bof_pkg::ID_W-1:0] s1_id_reg;
    logic signed [CW-1:0]     s1_min_x_reg, s1_max_x_reg, s1_min_y_reg, s1_max_y_reg;
    logic signed [CW-1:0]     s1_min_z_reg, s1_max_z_reg, s1_pos_x_reg, s1_pos_z_reg;
    logic [1:0]               s1_kind_reg;
    logic                     s1_last_reg;

    // stage 2: classified word
    logic                     s2_valid_reg;
    logic [bof_pkg::ID_W-1:0] s2_id_reg;
    logic [1:0]               s2_kind_reg;
    logic                     s2_last_reg;
    logic                     s2_hit_reg;
    logic                     s2_far_reg;

    logic [bof_pkg::CTR_W-1:0] sel_total_reg, sel_total_next;
    logic [bof_pkg::CTR_W-1:0] push_total_reg, push_total_next;
    logic                      abort_reg, abort_next;

    logic s2_adv, s1_adv, in_acc;
    logic ov_x, ov_y, ov_z, hit_c, far_c;
    logic [CW:0] dx, dz, adx, adz;
    logic live, sel_e, push_e;
    logic [bof_pkg::CTR_W-1:0] sel_cnt_c, push_cnt_c;
    logic abort_c;

    assign s2_adv   = !s2_valid_reg || !q_full;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_stall = s1_valid_reg && !s2_adv;
    assign in_acc   = in_valid && !in_stall;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg     <= bof_pkg::BOX_RESET;
            box_y_reg     <= bof_pkg::BOX_RESET;
            box_z_reg     <= bof_pkg::BOX_RESET;
            query_pos_reg <= '0;
            source_id_reg <= '1;
            push_thr_reg  <= bof_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                bof_pkg::REG_BOX_X:     box_x_reg     <= cfg_data;
                bof_pkg::REG_BOX_Y:     box_y_reg     <= cfg_data;
                bof_pkg::REG_BOX_Z:     box_z_reg     <= cfg_data;
                bof_pkg::REG_QUERY_POS: query_pos_reg <= cfg_data;
                bof_pkg::REG_SOURCE_ID: source_id_reg <= cfg_data[bof_pkg::ID_W-1:0];
                bof_pkg::REG_PUSH_THR:  push_thr_reg  <= cfg_data[bof_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_id_reg    <= entity_id;
            s1_min_x_reg <= min_x;
            s1_max_x_reg <= max_x;
            s1_min_y_reg <= min_y;
            s1_max_y_reg <= max_y;
            s1_min_z_reg <= min_z;
            s1_max_z_reg <= max_z;
            s1_pos_x_reg <= pos_x;
            s1_pos_z_reg <= pos_z;
            s1_kind_reg  <= kind;
            s1_last_reg  <= last_item;
        end
    end

    // classification
    always_comb
    begin
        ov_x = (s1_min_x_reg < $signed(box_x_reg[2*CW-1:CW]))
            && (s1_max_x_reg > $signed(box_x_reg[CW-1:0]));
        ov_y = (s1_min_y_reg < $signed(box_y_reg[2*CW-1:CW]))
            && (s1_max_y_reg > $signed(box_y_reg[CW-1:0]));
        ov_z = (s1_min_z_reg < $signed(box_z_reg[2*CW-1:CW]))
            && (s1_max_z_reg > $signed(box_z_reg[CW-1:0]));
        hit_c = ov_x && ov_y && ov_z && (s1_id_reg != source_id_reg);
        dx  = {query_pos_reg[CW-1], query_pos_reg[CW-1:0]}
            - {s1_pos_x_reg[CW-1], s1_pos_x_reg};
        dz  = {query_pos_reg[2*CW-1], query_pos_reg[2*CW-1:CW]}
            - {s1_pos_z_reg[CW-1], s1_pos_z_reg};
        adx = dx[CW] ? (~dx + 1'b1) : dx;
        adz = dz[CW] ? (~dz + 1'b1) : dz;
        far_c = (adx >= {2'b00, push_thr_reg}) || (adz >= {2'b00, push_thr_reg});
    end

    // stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_valid_reg)
        begin
            s2_id_reg   <= s1_id_reg;
            s2_kind_reg <= s1_kind_reg;
            s2_last_reg <= s1_last_reg;
            s2_hit_reg  <= hit_c;
            s2_far_reg  <= far_c;
        end
    end

    // batch counters
    always_comb
    begin
        live       = s2_valid_reg && !q_full;
        sel_e      = 1'b0;
        push_e     = 1'b0;
        sel_cnt_c  = sel_total_reg;
        push_cnt_c = push_total_reg;
        abort_c    = abort_reg;
        if (s2_hit_reg && !abort_reg)
        begin
            if (s2_kind_reg == bof_pkg::KIND_NEG || s2_kind_reg == bof_pkg::KIND_BAD_POS)
            begin
                abort_c = 1'b1;
            end
            else if (s2_kind_reg == bof_pkg::KIND_POS && sel_total_reg < bof_pkg::MAX_CNT)
            begin
                sel_e     = 1'b1;
                sel_cnt_c = sel_total_reg + 1'b1;
                if (s2_far_reg && push_total_reg < bof_pkg::MAX_CNT)
                begin
                    push_e     = 1'b1;
                    push_cnt_c = push_total_reg + 1'b1;
                end
            end
        end

        sel_total_next  = sel_total_reg;
        push_total_next = push_total_reg;
        abort_next      = abort_reg;
        if (live)
        begin
            if (s2_last_reg)
            begin
                sel_total_next  = '0;
                push_total_next = '0;
                abort_next      = 1'b0;
            end
            else
            begin
                sel_total_next  = sel_cnt_c;
                push_total_next = push_cnt_c;
                abort_next      = abort_c;
            end
        end

        q_wr             = live && (sel_e || s2_last_reg);
        q_wdata.sel      = sel_e;
        q_wdata.push     = push_e;
        q_wdata.sum      = s2_last_reg;
        q_wdata.id       = s2_id_reg;
        q_wdata.sel_cnt  = sel_cnt_c;
        q_wdata.push_cnt = push_cnt_c;
        q_wdata.abort    = abort_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_total_reg  <= '0;
            push_total_reg <= '0;
            abort_reg      <= 1'b0;
        end
        else
        begin
            sel_total_reg  <= sel_total_next;
            push_total_reg <= push_total_next;
            abort_reg      <= abort_next;
        end
    end

endmodule

@@ rtl/bof_queue.sv @@
// Short queue of per-item result entries between front and back.
module bof_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  bof_pkg::entry_t wdata,
    output logic            full,
    input  logic            rd,
    output logic            not_empty,
    output bof_pkg::entry_t rdata
);

    localparam int PW = $clog2(bof_pkg::QDEPTH);
    localparam int CW = $clog2(bof_pkg::QDEPTH + 1);

    bof_pkg::entry_t mem_reg [bof_pkg::QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;

    assign full      = (cnt_reg == CW'(bof_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rdata     = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= (wp_reg == PW'(bof_pkg::QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd)
            begin
                rp_reg <= (rp_reg == PW'(bof_pkg::QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/bof_back.sv @@
// Back part: expands queue entries into result words behind an output register.
module bof_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_not_empty,
    input  bof_pkg::entry_t               q_rdata,
    output logic                          q_rd,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    result_kind,
    output logic [bof_pkg::ID_W-1:0]      hit_id,
    output logic [bof_pkg::CNT_W-1:0]     selected_count,
    output logic [bof_pkg::CNT_W-1:0]     pushed_count,
    output logic                          aborted,
    output logic                          last_result
);

    logic [2:0] done_reg, done_next;
    logic [2:0] rem, pick;
    logic       load, is_last;
    logic       out_valid_reg;
    logic [1:0] kind_c;
    logic [bof_pkg::ID_W-1:0]  id_c;
    logic [bof_pkg::CTR_W-1:0] pcnt_c;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        rem = {q_rdata.sum, q_rdata.push, q_rdata.sel} & ~done_reg;
        if (rem[0])
        begin
            pick   = 3'b001;
            kind_c = bof_pkg::RES_SELECTED;
            id_c   = q_rdata.id;
            pcnt_c = q_rdata.push_cnt - {{(bof_pkg::CTR_W-1){1'b0}}, q_rdata.push};
        end
        else if (rem[1])
        begin
            pick   = 3'b010;
            kind_c = bof_pkg::RES_PUSHED;
            id_c   = q_rdata.id;
            pcnt_c = q_rdata.push_cnt;
        end
        else
        begin
            pick   = 3'b100;
            kind_c = bof_pkg::RES_SUMMARY;
            id_c   = '0;
            pcnt_c = q_rdata.push_cnt;
        end
        is_last   = ((rem & ~pick) == 3'b000);
        load      = q_not_empty && (!out_valid_reg || !out_stall);
        q_rd      = load && is_last;
        done_next = done_reg;
        if (load)
        begin
            done_next = is_last ? 3'b000 : (done_reg | pick);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (!out_valid_reg || !out_stall)
            begin
                out_valid_reg <= q_not_empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_kind    <= kind_c;
            hit_id         <= id_c;
            selected_count <= q_rdata.sel_cnt[bof_pkg::CNT_W-1:0];
            pushed_count   <= pcnt_c[bof_pkg::CNT_W-1:0];
            aborted        <= q_rdata.abort;
            last_result    <= is_last;
        end
    end

endmodule

@@ rtl/box_overlap_entity_filter_core.sv @@
// Top level of the box overlap entity filter.
// Entity records stream in one word per cycle while in_stall is low and are tested against
// the query box in a two-stage front end (capture, then signed overlap and distance compare)
// that also keeps the selected and pushed counts and the sticky abort of the batch. Each
// record that yields results leaves one entry in a four-deep queue; the back end turns it
// into one to three result words, one word per cycle while out_stall is low, through an
// output register, behind stage 1, stage 2 and the queue. Sustained rate is one record per
// cycle while records yield at most one word each and out_stall is low; the output port sets
// the rate when records yield more. Configuration is written through cfg_we, cfg_idx and
// cfg_data, by the user only while the block is idle; the block itself does not enforce it.
module box_overlap_entity_filter_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bof_pkg::IDX_W-1:0]         cfg_idx,
    input  logic [bof_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bof_pkg::ID_W-1:0]          entity_id,
    input  logic signed [bof_pkg::CRD_W-1:0]  min_x,
    input  logic signed [bof_pkg::CRD_W-1:0]  max_x,
    input  logic signed [bof_pkg::CRD_W-1:0]  min_y,
    input  logic signed [bof_pkg::CRD_W-1:0]  max_y,
    input  logic signed [bof_pkg::CRD_W-1:0]  min_z,
    input  logic signed [bof_pkg::CRD_W-1:0]  max_z,
    input  logic signed [bof_pkg::CRD_W-1:0]  pos_x,
    input  logic signed [bof_pkg::CRD_W-1:0]  pos_z,
    input  logic [1:0]                        kind,
    input  logic                              last_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        result_kind,
    output logic [bof_pkg::ID_W-1:0]          hit_id,
    output logic [bof_pkg::CNT_W-1:0]         selected_count,
    output logic [bof_pkg::CNT_W-1:0]         pushed_count,
    output logic                              aborted,
    output logic                              last_result
);

    logic            q_wr, q_full, q_rd, q_not_empty;
    bof_pkg::entry_t q_wdata, q_rdata;

    bof_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .entity_id (entity_id),
        .min_x     (min_x),
        .max_x     (max_x),
        .min_y     (min_y),
        .max_y     (max_y),
        .min_z     (min_z),
        .max_z     (max_z),
        .pos_x     (pos_x),
        .pos_z     (pos_z),
        .kind      (kind),
        .last_item (last_item),
        .q_wr      (q_wr),
        .q_wdata   (q_wdata),
        .q_full    (q_full)
    );

    bof_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_wr),
        .wdata     (q_wdata),
        .full      (q_full),
        .rd        (q_rd),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    bof_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_rdata        (q_rdata),
        .q_rd           (q_rd),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .hit_id         (hit_id),
        .selected_count (selected_count),
        .pushed_count   (pushed_count),
        .aborted        (aborted),
        .last_result    (last_result)
    );

endmodule

@@ verif/testbench.sv @@
// Testbench: box overlap entity filter checked word by word against a predictor of its filtering.
module testbench;
    import bof_pkg::*;

    localparam longint CRD_MIN = -64'sd2147483648;
    localparam longint CRD_MAX = 64'sd2147483647;
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [THR_W-1:0] THR_DEFAULT = THR_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam int PHASE_ITEMS = 30;
    localparam int PRINT_CAP = 100;

    typedef struct {
        logic [ID_W-1:0]         id;
        logic signed [CRD_W-1:0] mnx, mxx, mny, mxy, mnz, mxz, px, pz;
        logic [1:0]              kind;
        logic                    last;
    } entity_rec_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] sel;
        logic [CNT_W-1:0] push;
        logic             abort;
        logic             last;
    } hit_word_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [IDX_W-1:0]        cfg_idx = '0;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [ID_W-1:0]         entity_id = '0;
    logic signed [CRD_W-1:0] min_x = '0;
    logic signed [CRD_W-1:0] max_x = '0;
    logic signed [CRD_W-1:0] min_y = '0;
    logic signed [CRD_W-1:0] max_y = '0;
    logic signed [CRD_W-1:0] min_z = '0;
    logic signed [CRD_W-1:0] max_z = '0;
    logic signed [CRD_W-1:0] pos_x = '0;
    logic signed [CRD_W-1:0] pos_z = '0;
    logic [1:0]              kind = '0;
    logic                    last_item = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [1:0]              result_kind;
    logic [ID_W-1:0]         hit_id;
    logic [CNT_W-1:0]        selected_count;
    logic [CNT_W-1:0]        pushed_count;
    logic                    aborted;
    logic                    last_result;

    // predictor copy of the registers and batch state
    logic [CFG_W-1:0] box_x_q = BOX_RESET;
    logic [CFG_W-1:0] box_y_q = BOX_RESET;
    logic [CFG_W-1:0] box_z_q = BOX_RESET;
    logic [CFG_W-1:0] qpos_q = '0;
    logic [ID_W-1:0]  src_q = '1;
    logic [THR_W-1:0] thr_q = THR_DEFAULT;
    int               sel_total = 0;
    int               push_total = 0;
    bit               abort_q = 1'b0;

    hit_word_t hits_due[$];
    hit_word_t want;
    int        err_count = 0;
    bit        quiet = 1'b0;
    int        hold_len = 0;
    int        hold_seq = 0;
    int        hold_seen = 0;
    int        hold_cnt = 0;

    box_overlap_entity_filter_core DUT (.*);

    always #5 clk = ~clk;

    function automatic bit axis_hit(input logic [CFG_W-1:0] q, input logic signed [CRD_W-1:0] lo,
                                    input logic signed [CRD_W-1:0] hi);
        logic signed [CRD_W-1:0] qlo, qhi;
        qlo = q[31:0];
        qhi = q[63:32];
        return (lo < qhi) && (hi > qlo);
    endfunction

    function automatic hit_word_t hit_word(input logic [1:0] k, input logic [ID_W-1:0] id);
        hit_word_t w;
        w.kind = k;
        w.id = id;
        w.sel = CNT_W'(sel_total);
        w.push = CNT_W'(push_total);
        w.abort = abort_q;
        w.last = 1'b0;
        return w;
    endfunction

    function automatic void predict_hits(input entity_rec_t r);
        hit_word_t               words[$];
        longint                  dx, dz, lim;
        logic signed [CRD_W-1:0] qx, qz;
        bit                      far;
        qx = qpos_q[31:0];
        qz = qpos_q[63:32];
        if (!abort_q && r.id != src_q && axis_hit(box_x_q, r.mnx, r.mxx)
            && axis_hit(box_y_q, r.mny, r.mxy) && axis_hit(box_z_q, r.mnz, r.mxz))
        begin
            if (r.kind == KIND_NEG || r.kind == KIND_BAD_POS)
                abort_q = 1'b1;
            else if (r.kind == KIND_POS && sel_total < MAX_ENTRIES)
            begin
                dx = qx;
                dx = dx - r.px;
                if (dx < 0)
                    dx = -dx;
                dz = qz;
                dz = dz - r.pz;
                if (dz < 0)
                    dz = -dz;
                lim = thr_q;
                far = (dx >= lim) || (dz >= lim);
                sel_total++;
                words.push_back(hit_word(RES_SELECTED, r.id));
                if (far && push_total < MAX_ENTRIES)
                begin
                    push_total++;
                    words.push_back(hit_word(RES_PUSHED, r.id));
                end
            end
        end
        if (r.last)
        begin
            words.push_back(hit_word(RES_SUMMARY, '0));
            sel_total = 0;
            push_total = 0;
            abort_q = 1'b0;
        end
        if (words.size() > 0)
            words[words.size() - 1].last = 1'b1;
        foreach (words[i])
            hits_due.push_back(words[i]);
    endfunction

    function automatic void check_field(input string name, input logic [ID_W-1:0] want_v,
                                        input logic [ID_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            err_count++;
            if (err_count <= PRINT_CAP)
                $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (hits_due.size() == 0)
            begin
                err_count++;
                if (err_count <= PRINT_CAP)
                    $display("%0t: extra word expected none actual kind %0d id %0h",
                             $time, result_kind, hit_id);
            end
            else
            begin
                want = hits_due.pop_front();
                check_field("result_kind", want.kind, result_kind);
                check_field("hit_id", want.id, hit_id);
                check_field("selected_count", want.sel, selected_count);
                check_field("pushed_count", want.push, pushed_count);
                check_field("aborted", want.abort, aborted);
                check_field("last_result", want.last, last_result);
            end
        end
    end

    // receiver: random stalls, or a counted hold-off when requested
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_cnt <= hold_len;
            out_stall <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 37);
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BOX_X:     box_x_q = val;
            REG_BOX_Y:     box_y_q = val;
            REG_BOX_Z:     box_z_q = val;
            REG_QUERY_POS: qpos_q = val;
            REG_SOURCE_ID: src_q = val[ID_W-1:0];
            REG_PUSH_THR:  thr_q = val[THR_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic send_entity(input entity_rec_t r);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(99) < 37)
            gap = $urandom_range(3, 1);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        entity_id <= r.id;
        min_x <= r.mnx;
        max_x <= r.mxx;
        min_y <= r.mny;
        max_y <= r.mxy;
        min_z <= r.mnz;
        max_z <= r.mxz;
        pos_x <= r.px;
        pos_z <= r.pz;
        kind <= r.kind;
        last_item <= r.last;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_hits(r);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (hits_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pack_box(input logic signed [CRD_W-1:0] lo,
                                                  input logic signed [CRD_W-1:0] hi);
        return {hi, lo};
    endfunction

    function automatic entity_rec_t mk_entity(input logic [ID_W-1:0] id,
        input logic signed [CRD_W-1:0] mnx, input logic signed [CRD_W-1:0] mxx,
        input logic signed [CRD_W-1:0] mny, input logic signed [CRD_W-1:0] mxy,
        input logic signed [CRD_W-1:0] mnz, input logic signed [CRD_W-1:0] mxz,
        input logic signed [CRD_W-1:0] px, input logic signed [CRD_W-1:0] pz,
        input logic [1:0] k, input logic last);
        entity_rec_t r;
        r.id = id;
        r.mnx = mnx;
        r.mxx = mxx;
        r.mny = mny;
        r.mxy = mxy;
        r.mnz = mnz;
        r.mxz = mxz;
        r.px = px;
        r.pz = pz;
        r.kind = k;
        r.last = last;
        return r;
    endfunction

    // box well inside the directed query box
    function automatic entity_rec_t inside_entity(input logic [ID_W-1:0] id,
        input logic signed [CRD_W-1:0] px, input logic signed [CRD_W-1:0] pz,
        input logic [1:0] k, input logic last);
        return mk_entity(id, -10, 10, 10, 20, -5, 5, px, pz, k, last);
    endfunction

    function automatic logic [CRD_W-1:0] pick_below(input logic signed [CRD_W-1:0] lim);
        longint l;
        l = lim;
        if (l == CRD_MIN)
            return $urandom;
        if ($urandom_range(4) == 0)
            return CRD_W'(l - 1);
        return CRD_W'(CRD_MIN + longint'($urandom_range(32'(l - 1 - CRD_MIN), 0)));
    endfunction

    function automatic logic [CRD_W-1:0] pick_above(input logic signed [CRD_W-1:0] lim);
        longint l;
        l = lim;
        if (l == CRD_MAX)
            return $urandom;
        if ($urandom_range(4) == 0)
            return CRD_W'(l + 1);
        return CRD_W'(l + 1 + longint'($urandom_range(32'(CRD_MAX - l - 1), 0)));
    endfunction

    // position around the push threshold from the query point
    function automatic logic [CRD_W-1:0] pick_near(input logic signed [CRD_W-1:0] q);
        longint span, off;
        if ($urandom_range(3) == 0)
            return $urandom;
        span = thr_q;
        span = 2 * span + 2;
        if (span > CRD_MAX)
            span = CRD_MAX;
        off = longint'($urandom_range(32'(2 * span), 0)) - span;
        return CRD_W'(longint'(q) + off);
    endfunction

    function automatic entity_rec_t rand_entity();
        entity_rec_t r;
        int          pick;
        r.id = ID_W'({$urandom, $urandom});
        if ($urandom_range(19) == 0)
            r.id = src_q;
        if ($urandom_range(99) < 15)
        begin
            r.mnx = $urandom;
            r.mxx = $urandom;
            r.mny = $urandom;
            r.mxy = $urandom;
            r.mnz = $urandom;
            r.mxz = $urandom;
            r.px = $urandom;
            r.pz = $urandom;
            r.kind = 2'($urandom_range(3));
        end
        else
        begin
            r.mnx = pick_below(box_x_q[63:32]);
            r.mxx = pick_above(box_x_q[31:0]);
            r.mny = pick_below(box_y_q[63:32]);
            r.mxy = pick_above(box_y_q[31:0]);
            r.mnz = pick_below(box_z_q[63:32]);
            r.mxz = pick_above(box_z_q[31:0]);
            r.px = pick_near(qpos_q[31:0]);
            r.pz = pick_near(qpos_q[63:32]);
            pick = $urandom_range(99);
            r.kind = (pick < 14) ? KIND_ZERO : (pick < 92) ? KIND_POS :
                     (pick < 96) ? KIND_NEG : KIND_BAD_POS;
        end
        r.last = ($urandom_range(99) < 10);
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] rand_box();
        logic signed [CRD_W-1:0] a, b;
        int                      m;
        m = $urandom_range(9);
        a = $urandom;
        b = $urandom;
        if (m == 0)
            return BOX_RESET;
        if (m == 1)
            return {a, b};
        return (a > b) ? {a, b} : {b, a};
    endfunction

    function automatic logic [CFG_W-1:0] rand_thr();
        int m;
        m = $urandom_range(9);
        if (m == 0)
            return {$urandom, 32'h0000_0000};
        if (m == 1)
            return {$urandom, $urandom};
        return {$urandom, 1'($urandom), 31'($urandom_range(4000))};
    endfunction

    task automatic test_reset_values();
        send_entity(mk_entity(1, -10, 10, -10, 10, -10, 10, 0, 0, KIND_POS, 1'b0));
        send_entity(mk_entity(2, -10, 10, -10, 10, -10, 10, 655, 0, KIND_POS, 1'b0));
        send_entity(mk_entity(3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 0, 1, 0, 0,
                              KIND_POS, 1'b0));
        send_entity(mk_entity(4, 0, 1, 0, 1, 32'h8000_0000, 32'h8000_0000, 0, 0,
                              KIND_POS, 1'b0));
        send_entity(mk_entity('1, 0, 1, 0, 1, 0, 1, 900, 0, KIND_POS, 1'b0));
        send_entity(mk_entity(5, 0, 1, 0, 1, 0, 1, 0, 0, KIND_ZERO, 1'b1));
        wait_drain();
    endtask

    task automatic test_directed_cases();
        write_reg(REG_BOX_X, pack_box(-1000, 1000));
        write_reg(REG_BOX_Y, pack_box(0, 100));
        write_reg(REG_BOX_Z, pack_box(-50, 50));
        write_reg(REG_QUERY_POS, '0);
        write_reg(REG_SOURCE_ID, 64'h8000_0005_0000_0007);
        write_reg(REG_PUSH_THR, 64'd100);
        send_entity(inside_entity(10, 10, 10, KIND_POS, 1'b0));
        send_entity(inside_entity(11, 100, 0, KIND_POS, 1'b0));
        send_entity(inside_entity(12, 0, -100, KIND_POS, 1'b0));
        send_entity(inside_entity(13, 99, -99, KIND_POS, 1'b0));
        // touching faces do not overlap
        send_entity(mk_entity(14, 1000, 2000, 10, 20, -5, 5, 0, 0, KIND_POS, 1'b0));
        send_entity(mk_entity(15, -2000, -1000, 10, 20, -5, 5, 0, 0, KIND_POS, 1'b0));
        send_entity(mk_entity(16, 999, 2000, 99, 101, 49, 60, 500, 0, KIND_POS, 1'b0));
        send_entity(mk_entity(17, -10, 10, 100, 200, -5, 5, 0, 0, KIND_POS, 1'b0));
        send_entity(mk_entity(18, -10, 10, 10, 20, -60, -50, 0, 0, KIND_POS, 1'b0));
        send_entity(inside_entity(19, 0, 0, KIND_ZERO, 1'b0));
        send_entity(inside_entity(63'h5_0000_0007, 0, 0, KIND_NEG, 1'b0));
        send_entity(mk_entity(20, 1000, 1001, 10, 20, -5, 5, 0, 0, KIND_NEG, 1'b0));
        send_entity(inside_entity(21, 500, 500, KIND_POS, 1'b1));
        send_entity(inside_entity(22, 0, 0, KIND_NEG, 1'b0));
        send_entity(inside_entity(23, 500, 0, KIND_POS, 1'b0));
        send_entity(inside_entity(24, 0, 0, KIND_ZERO, 1'b1));
        send_entity(inside_entity(25, 0, 0, KIND_BAD_POS, 1'b0));
        send_entity(inside_entity(26, 500, 0, KIND_POS, 1'b1));
        wait_drain();
        write_reg(REG_SPARE_LO, {$urandom, $urandom});
        write_reg(REG_SPARE_HI, {$urandom, $urandom});
        write_reg(REG_BOX_X, BOX_RESET);
        write_reg(REG_BOX_Y, BOX_RESET);
        write_reg(REG_BOX_Z, BOX_RESET);
        write_reg(REG_QUERY_POS, {32'h7FFF_FFFF, 32'h8000_0000});
        write_reg(REG_PUSH_THR, '1);
        send_entity(mk_entity(27, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                              KIND_POS, 1'b0));
        send_entity(mk_entity('1, -1, 1, -1, 1, -1, 1, 0, 32'h7FFF_FFFF, KIND_POS, 1'b0));
        send_entity(mk_entity(29, -1, 1, -1, 1, -1, 1, -2, 1, KIND_POS, 1'b1));
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        write_reg(REG_BOX_X, BOX_RESET);
        write_reg(REG_BOX_Y, BOX_RESET);
        write_reg(REG_BOX_Z, BOX_RESET);
        write_reg(REG_QUERY_POS, '0);
        write_reg(REG_SOURCE_ID, '1);
        write_reg(REG_PUSH_THR, '0);
        quiet = 1'b1;
        hold_len = 120;
        hold_seq++;
        for (int i = 0; i < 30; i++)
            send_entity(mk_entity(ID_W'(100 + i), -5, 5, -5, 5, -5, 5, i, -i, KIND_POS,
                                  i == 29));
        quiet = 1'b0;
        wait_drain();
    endtask

    task automatic test_random_batches();
        entity_rec_t r;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_BOX_X, BOX_RESET);
                    write_reg(REG_BOX_Y, BOX_RESET);
                    write_reg(REG_BOX_Z, BOX_RESET);
                    write_reg(REG_QUERY_POS, {32'h8000_0000, 32'h7FFF_FFFF});
                    write_reg(REG_SOURCE_ID, '0);
                    write_reg(REG_PUSH_THR, '1);
                end
                1:
                begin
                    write_reg(REG_BOX_X, rand_box());
                    write_reg(REG_BOX_Y, rand_box());
                    write_reg(REG_BOX_Z, rand_box());
                    write_reg(REG_QUERY_POS, {32'h7FFF_FFFF, 32'h8000_0000});
                    write_reg(REG_SOURCE_ID, '1);
                    write_reg(REG_PUSH_THR, '0);
                end
                default:
                begin
                    write_reg(REG_BOX_X, rand_box());
                    write_reg(REG_BOX_Y, rand_box());
                    write_reg(REG_BOX_Z, rand_box());
                    write_reg(REG_QUERY_POS, {$urandom, $urandom});
                    write_reg(REG_SOURCE_ID, {$urandom, $urandom});
                    write_reg(REG_PUSH_THR, rand_thr());
                end
            endcase
            // one phase runs with no idling on either side
            quiet = (phase == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                r = rand_entity();
                if (i == PHASE_ITEMS - 1)
                    r.last = 1'b1;
                send_entity(r);
            end
            wait_drain();
            quiet = 1'b0;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_directed_cases();
        test_output_backpressure();
        test_random_batches();
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
